/* rtl/p2plm_pkg.sv */
// Shared constants, types and mapping helpers for the peak-to-peak level meter.
package p2plm_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int SPAN_FIELD_W  = 12;
  localparam int HEIGHT_W      = 6;
  localparam int HISTORY_DEPTH = 10;
  localparam int HIST_SLOTS    = 10;
  localparam int HIST_FIELD_W  = HIST_SLOTS * HEIGHT_W;
  localparam int FULL_SCALE    = 40;
  localparam int NOISE_FLOOR   = 20;

  localparam int IN_TDATA_W  = ((SPAN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = HEIGHT_W + SPAN_FIELD_W + HIST_FIELD_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [HEIGHT_W-1:0]    height_t;

  // Sensitivity modes, each picking a mapping ceiling.
  typedef enum logic [1:0] {
    SENS_3200 = 2'd0,
    SENS_1800 = 2'd1,
    SENS_550  = 2'd2,
    SENS_180  = 2'd3
  } sens_mode_t;

  localparam sens_mode_t SENS_RESET = SENS_550;

  // Divisors are ceiling minus noise floor.
  localparam int DIV_3200 = 3200 - NOISE_FLOOR;
  localparam int DIV_1800 = 1800 - NOISE_FLOOR;
  localparam int DIV_550  = 550 - NOISE_FLOOR;
  localparam int DIV_180  = 180 - NOISE_FLOOR;

  // Reciprocals scaled by 2^RECIP_SHIFT, rounded up. With the numerator below
  // 2^18 and divisors below 2^12 the truncated product is the exact quotient.
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 26;
  localparam int NUM_W       = SAMPLE_BITS + HEIGHT_W;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_3200 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_3200) - 64'd1) / 64'(DIV_3200));
  localparam logic [RECIP_W-1:0] RECIP_1800 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_1800) - 64'd1) / 64'(DIV_1800));
  localparam logic [RECIP_W-1:0] RECIP_550 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_550) - 64'd1) / 64'(DIV_550));
  localparam logic [RECIP_W-1:0] RECIP_180 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_180) - 64'd1) / 64'(DIV_180));

  function automatic sample_t divisor_of(sens_mode_t mode);
    sample_t d;
    unique case (mode)
      SENS_3200: d = SAMPLE_BITS'(DIV_3200);
      SENS_1800: d = SAMPLE_BITS'(DIV_1800);
      SENS_550:  d = SAMPLE_BITS'(DIV_550);
      SENS_180:  d = SAMPLE_BITS'(DIV_180);
      default:   d = SAMPLE_BITS'(DIV_550);
    endcase
    return d;
  endfunction

  function automatic logic [RECIP_W-1:0] recip_of(sens_mode_t mode);
    logic [RECIP_W-1:0] r;
    unique case (mode)
      SENS_3200: r = RECIP_3200;
      SENS_1800: r = RECIP_1800;
      SENS_550:  r = RECIP_550;
      SENS_180:  r = RECIP_180;
      default:   r = RECIP_550;
    endcase
    return r;
  endfunction

endpackage

/* rtl/peak_to_peak_level_meter_top.sv */
// Top level of the peak-to-peak level meter with its stream and config ports.
//
// The meter takes one microphone sample per transaction on the in_ stream and
// keeps the running maximum and minimum of the current window. The sample that
// arrives with in_tlast high is folded in first, then the window closes: the
// span (maximum minus minimum) is mapped linearly from a noise floor of 20 up
// to the ceiling picked by the sensitivity mode (3200, 1800, 550 or 180) onto
// 0..40, truncated and clamped. That height is pushed into a ten-entry history
// (cleared at reset) and one result transaction carries height, span and the
// packed history. Samples without in_tlast produce no result. The block takes
// one sample per clock cycle while in_tready is high. A closing sample passes
// through two registers: the span register, then the result register, which
// offers its result on out_. Backpressure on out_ holds the result register
// and then the span register; in_tready drops only when both hold a window
// that has not moved on. The sensitivity mode is written through the cfg_
// channel, which is always ready, and resets to mode 2 (ceiling 550); write
// it only while no window result is pending.
module peak_to_peak_level_meter_top (
  input  logic        clk,
  input  logic        rst_n,
  // Sample stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sample_value, [15:12] zero
  input  logic        in_tlast,   // window_last
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [5:0] bar_height, [17:6] peak_span,
                                  // [77:18] history_packed, [79:78] zero
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // sensitivity_mode
);
  import p2plm_pkg::*;

  sens_mode_t mode_r;

  sample_t    hi_r, hi_nxt;
  sample_t    lo_r, lo_nxt;
  sample_t    sample;
  sample_t    cur_hi, cur_lo;

  logic       span_vld_r, span_vld_nxt;
  sample_t    span_r;

  logic       res_ready;
  logic       span_adv;
  logic       in_fire;

  height_t    height;
  height_t    height_r;
  sample_t    span_out_r;
  height_t    hist_r [HISTORY_DEPTH];
  logic [HIST_FIELD_W-1:0] hist_packed;
  logic       out_vld_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= SENS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= sens_mode_t'(cfg_data);
    end
  end

  // Handshake between the span stage and the result register.
  assign res_ready = !out_tvalid || out_tready;
  assign span_adv  = span_vld_r && res_ready;
  assign in_tready = !span_vld_r || res_ready;
  assign in_fire   = in_tvalid && in_tready;

  // Running extremes including the sample on the bus.
  assign sample = in_tdata[SAMPLE_BITS-1:0];
  assign cur_hi = (sample > hi_r) ? sample : hi_r;
  assign cur_lo = (sample < lo_r) ? sample : lo_r;

  always_comb begin
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    span_vld_nxt = span_adv ? 1'b0 : span_vld_r;
    if (in_fire) begin
      if (in_tlast) begin
        // Window closes: rearm the extremes for the next one.
        hi_nxt       = '0;
        lo_nxt       = '1;
        span_vld_nxt = 1'b1;
      end else begin
        hi_nxt = cur_hi;
        lo_nxt = cur_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r       <= '0;
      lo_r       <= '1;
      span_vld_r <= 1'b0;
    end else begin
      hi_r       <= hi_nxt;
      lo_r       <= lo_nxt;
      span_vld_r <= span_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      span_r <= (cur_hi >= cur_lo) ? (cur_hi - cur_lo) : '0;
    end
  end

  p2plm_height_map u_height_map (
    .span   (span_r),
    .mode   (mode_r),
    .height (height)
  );

  // Result register and history. The history only shifts when the previous
  // result has been taken, so it doubles as the output's history field.
  assign out_vld_nxt = span_adv ? 1'b1 : (out_tready ? 1'b0 : out_tvalid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      out_tvalid <= out_vld_nxt;
      if (span_adv) begin
        hist_r[0] <= height;
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
          hist_r[i] <= hist_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (span_adv) begin
      height_r   <= height;
      span_out_r <= span_r;
    end
  end

  always_comb begin
    hist_packed = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hist_packed[i*HEIGHT_W +: HEIGHT_W] = hist_r[i];
    end
  end

  assign out_tdata = OUT_TDATA_W'({hist_packed, SPAN_FIELD_W'(span_out_r), height_r});

endmodule

/* rtl/p2plm_height_map.sv */
// Linear span-to-height mapping with noise floor, truncation and clamping.
module p2plm_height_map (
  input  p2plm_pkg::sample_t    span,
  input  p2plm_pkg::sens_mode_t mode,
  output p2plm_pkg::height_t    height
);
  import p2plm_pkg::*;

  sample_t            diff;
  sample_t            divisor;
  logic [NUM_W-1:0]   num;
  logic [PROD_W-1:0]  prod;

  assign diff    = span - SAMPLE_BITS'(NOISE_FLOOR);
  assign divisor = divisor_of(mode);
  assign num     = NUM_W'(diff) * NUM_W'(FULL_SCALE);
  assign prod    = PROD_W'(num) * PROD_W'(recip_of(mode));

  always_comb begin
    priority if (span <= SAMPLE_BITS'(NOISE_FLOOR)) begin
      height = '0;
    end else if (diff >= divisor) begin
      // The quotient would reach full scale or beyond.
      height = HEIGHT_W'(FULL_SCALE);
    end else begin
      height = prod[RECIP_SHIFT +: HEIGHT_W];
    end
  end

endmodule
